// ----- design/function_call_tracer_macros.svh -----
// Assertion macros shared by the function call tracer modules.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef FUNCTION_CALL_TRACER_MACROS_SVH
`define FUNCTION_CALL_TRACER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FCT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fct_pkg.sv -----
// Types and constants for the function call tracer.
// No dependencies; used by every module of the block.
`default_nettype none

package fct_pkg;

    localparam int unsigned XLEN        = 32;
    localparam int unsigned SLOT_W      = 6;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned LEVEL_W     = 7;
    localparam int unsigned QUEUE_DEPTH = 2;

    // jalr x0, 0(x1)
    localparam logic [XLEN-1:0] RET_WORD = 32'h0000_8067;

    localparam logic EVT_CALL = 1'b0;
    localparam logic EVT_RET  = 1'b1;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_TRACE = 1'b1;

    typedef struct packed {
        logic              is_trace;
        logic              load_ok;
        logic              is_ret;
        logic [SLOT_W-1:0] slot;
        logic [XLEN-1:0]   entry_start;
        logic [XLEN-1:0]   entry_name;
        logic [XLEN-1:0]   pc;
        logic [XLEN-1:0]   target;
    } fct_req_t;

    typedef struct packed {
        logic               event_res;
        logic [XLEN-1:0]    event_pc;
        logic [LEVEL_W-1:0] nest_level;
        logic [XLEN-1:0]    name_offset;
        logic [XLEN-1:0]    call_target;
        logic               last_of_run;
    } fct_evt_t;

    typedef struct packed {
        logic [XLEN-1:0] start;
        logic [XLEN-1:0] name;
    } fct_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RET,
        ST_CALL
    } fct_state_t;

endpackage

`default_nettype wire

// ----- design/function_call_tracer.sv -----
// Function call tracer top level: front end, request queue, back end and
// result queue. Depends on fct_pkg, fct_front, fct_queue and fct_back.
`default_nettype none

// Traces calls and returns in a retired instruction stream. Load requests
// (func = 0) fill the function table; trace requests (func = 1) are matched
// against the first entry_count table entries and against the return word,
// giving up to two result requests (ret first, then call). A load writes the
// table memory from the idle state. A trace is taken from the idle state, then
// scans the table memory from the highest searched slot down at one entry a
// cycle, ending early on a hit, then hands each result to the result queue,
// waiting while that queue is full; the single read port of the table memory
// sets the scan rate. A two-entry queue sits in front of the back end and
// another holds results, so input and output stall independently. Table and
// stack contents are not cleared by reset; only loaded slots may be searched.
module function_call_tracer #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned STACK_DEPTH   = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [fct_pkg::COUNT_W-1:0]   cfg_wdata,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          func,
    input  wire logic [fct_pkg::SLOT_W-1:0]    slot,
    input  wire logic [fct_pkg::XLEN-1:0]      entry_start,
    input  wire logic [fct_pkg::XLEN-1:0]      entry_name,
    input  wire logic [fct_pkg::XLEN-1:0]      pc,
    input  wire logic [fct_pkg::XLEN-1:0]      target,
    input  wire logic [fct_pkg::XLEN-1:0]      instr,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               event_res,
    output logic [fct_pkg::XLEN-1:0]           event_pc,
    output logic [fct_pkg::LEVEL_W-1:0]        nest_level,
    output logic [fct_pkg::XLEN-1:0]           name_offset,
    output logic [fct_pkg::XLEN-1:0]           call_target,
    output logic                               last_of_run
);

    logic                   req_push, req_full, req_empty, req_pop;
    fct_pkg::fct_req_t      req_in, req_out;
    logic                   evt_push, evt_full;
    fct_pkg::fct_evt_t      evt_in, evt_out;

    fct_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .push        (push),
        .full        (full),
        .func        (func),
        .slot        (slot),
        .entry_start (entry_start),
        .entry_name  (entry_name),
        .pc          (pc),
        .target      (target),
        .instr       (instr),
        .req_push    (req_push),
        .req_data    (req_in),
        .req_full    (req_full)
    );

    fct_queue #(
        .T (fct_pkg::fct_req_t)
    ) u_req_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (req_push),
        .wdata (req_in),
        .full  (req_full),
        .pop   (req_pop),
        .rdata (req_out),
        .empty (req_empty)
    );

    fct_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_empty (req_empty),
        .req_data  (req_out),
        .req_pop   (req_pop),
        .evt_full  (evt_full),
        .evt_push  (evt_push),
        .evt_data  (evt_in)
    );

    fct_queue #(
        .T (fct_pkg::fct_evt_t)
    ) u_evt_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (evt_push),
        .wdata (evt_in),
        .full  (evt_full),
        .pop   (pop),
        .rdata (evt_out),
        .empty (empty)
    );

    assign event_res   = evt_out.event_res;
    assign event_pc    = evt_out.event_pc;
    assign nest_level  = evt_out.nest_level;
    assign name_offset = evt_out.name_offset;
    assign call_target = evt_out.call_target;
    assign last_of_run = evt_out.last_of_run;

endmodule

`default_nettype wire

// ----- design/fct_queue.sv -----
// Small FIFO used between front and back, and for the result requests.
// Depends on fct_pkg and function_call_tracer_macros.svh.
`default_nettype none

`include "function_call_tracer_macros.svh"

module fct_queue #(
    parameter type T = logic
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire T     wdata,
    output logic      full,
    input  wire logic pop,
    output T          rdata,
    output logic      empty
);

    localparam int unsigned DEPTH = fct_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    T                   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    `FCT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH), "queue count above depth")
    `FCT_ASSERT_NXT(a_cnt_grow, do_push && !do_pop, cnt_reg == $past(cnt_reg) + 1'b1, "queue count did not grow on push")

endmodule

`default_nettype wire

// ----- design/fct_front.sv -----
// Front end: takes input requests, decodes the request kind and the return
// encoding, and hands a packed request to the queue. Depends on fct_pkg.
`default_nettype none

module fct_front #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          func,
    input  wire logic [fct_pkg::SLOT_W-1:0]    slot,
    input  wire logic [fct_pkg::XLEN-1:0]      entry_start,
    input  wire logic [fct_pkg::XLEN-1:0]      entry_name,
    input  wire logic [fct_pkg::XLEN-1:0]      pc,
    input  wire logic [fct_pkg::XLEN-1:0]      target,
    input  wire logic [fct_pkg::XLEN-1:0]      instr,
    output logic                               req_push,
    output fct_pkg::fct_req_t                  req_data,
    input  wire logic                          req_full
);

    assign full     = req_full;
    assign req_push = push && !req_full;

    always_comb
    begin
        req_data             = '0;
        req_data.is_trace    = (func == fct_pkg::FUNC_TRACE);
        // slots past the table are dropped
        req_data.load_ok     = (func == fct_pkg::FUNC_LOAD) &&
                               (32'(slot) < 32'(TABLE_ENTRIES));
        req_data.is_ret      = (instr == fct_pkg::RET_WORD);
        req_data.slot        = slot;
        req_data.entry_start = entry_start;
        req_data.entry_name  = entry_name;
        req_data.pc          = pc;
        req_data.target      = target;
    end

endmodule

`default_nettype wire

// ----- design/fct_back.sv -----
// Back end: function table and call stack memories, table search and event
// generation. Depends on fct_pkg and function_call_tracer_macros.svh.
`default_nettype none

`include "function_call_tracer_macros.svh"

module fct_back #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned STACK_DEPTH   = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [fct_pkg::COUNT_W-1:0]   cfg_wdata,
    input  wire logic                          req_empty,
    input  wire fct_pkg::fct_req_t             req_data,
    output logic                               req_pop,
    input  wire logic                          evt_full,
    output logic                               evt_push,
    output fct_pkg::fct_evt_t                  evt_data
);

    localparam int unsigned TBL_AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned STK_AW = $clog2(STACK_DEPTH);
    localparam int unsigned DEP_W  = $clog2(STACK_DEPTH + 1);

    fct_pkg::fct_state_t            state_reg, state_next;
    fct_pkg::fct_req_t              cur_reg, cur_next;
    logic [fct_pkg::COUNT_W-1:0]    entry_count_reg;
    logic [TBL_AW-1:0]              idx_reg, idx_next;
    logic                           pend_reg, pend_next;
    logic                           pend_last_reg, pend_last_next;
    logic                           hit_reg, hit_next;
    logic [fct_pkg::XLEN-1:0]       hit_name_reg, hit_name_next;
    logic [DEP_W-1:0]               depth_reg, depth_next;

    fct_pkg::fct_entry_t            tbl_mem [TABLE_ENTRIES];
    fct_pkg::fct_entry_t            tbl_rd_reg;
    logic                           tbl_we, tbl_re;
    logic [TBL_AW-1:0]              tbl_waddr, tbl_raddr;
    fct_pkg::fct_entry_t            tbl_wdata;

    logic [fct_pkg::XLEN-1:0]       frame_mem [STACK_DEPTH];
    logic [fct_pkg::XLEN-1:0]       stk_rd_reg;
    logic                           stk_we, stk_re;
    logic [STK_AW-1:0]              stk_waddr, stk_raddr;
    logic [fct_pkg::XLEN-1:0]       stk_wdata;

    logic [31:0]                    ec_wide;
    logic [TBL_AW-1:0]              first_idx;
    logic                           hit_now;
    logic                           search_done;
    logic [DEP_W-1:0]               dep_after;

    assign ec_wide   = 32'(entry_count_reg);
    assign first_idx = (ec_wide < 32'(TABLE_ENTRIES)) ? TBL_AW'(ec_wide - 32'd1)
                                                      : TBL_AW'(TABLE_ENTRIES - 1);
    assign hit_now   = pend_reg && (tbl_rd_reg.start == cur_reg.target);
    assign dep_after = (depth_reg < DEP_W'(STACK_DEPTH)) ? depth_reg + 1'b1 : depth_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        hit_next       = hit_reg;
        hit_name_next  = hit_name_reg;
        depth_next     = depth_reg;
        req_pop        = 1'b0;
        tbl_we         = 1'b0;
        tbl_waddr      = TBL_AW'(req_data.slot);
        tbl_wdata.start = req_data.entry_start;
        tbl_wdata.name  = req_data.entry_name;
        tbl_re         = 1'b0;
        tbl_raddr      = idx_reg;
        stk_we         = 1'b0;
        stk_waddr      = STK_AW'(dep_after - 1'b1);
        stk_wdata      = hit_name_reg;
        stk_re         = 1'b0;
        stk_raddr      = STK_AW'(depth_reg - 1'b1);
        evt_push       = 1'b0;
        evt_data       = '0;
        search_done    = 1'b0;

        case (state_reg)
            fct_pkg::ST_IDLE:
            begin
                if (!req_empty)
                begin
                    req_pop = 1'b1;
                    if (!req_data.is_trace)
                    begin
                        tbl_we = req_data.load_ok;
                    end
                    else
                    begin
                        cur_next = req_data;
                        hit_next = 1'b0;
                        idx_next = first_idx;
                        // top frame is fetched now, ready by the ret event
                        stk_re   = (depth_reg != '0);
                        if (entry_count_reg != '0)
                        begin
                            state_next = fct_pkg::ST_SEARCH;
                        end
                        else if (req_data.is_ret)
                        begin
                            state_next = fct_pkg::ST_RET;
                        end
                    end
                end
            end

            fct_pkg::ST_SEARCH:
            begin
                // highest slot first; the first hit ends the scan
                if (hit_now)
                begin
                    hit_next      = 1'b1;
                    hit_name_next = tbl_rd_reg.name;
                    search_done   = 1'b1;
                end
                else if (pend_reg && pend_last_reg)
                begin
                    search_done = 1'b1;
                end
                else
                begin
                    tbl_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_last_next = (idx_reg == '0);
                    idx_next       = idx_reg - 1'b1;
                end
                if (search_done)
                begin
                    if (cur_reg.is_ret)
                    begin
                        state_next = fct_pkg::ST_RET;
                    end
                    else if (hit_now)
                    begin
                        state_next = fct_pkg::ST_CALL;
                    end
                    else
                    begin
                        state_next = fct_pkg::ST_IDLE;
                    end
                end
            end

            fct_pkg::ST_RET:
            begin
                evt_data.event_res   = fct_pkg::EVT_RET;
                evt_data.event_pc    = cur_reg.pc;
                evt_data.nest_level  = fct_pkg::LEVEL_W'(depth_reg);
                evt_data.name_offset = (depth_reg != '0) ? stk_rd_reg : '0;
                evt_data.call_target = '0;
                evt_data.last_of_run = !hit_reg;
                if (!evt_full)
                begin
                    evt_push   = 1'b1;
                    depth_next = (depth_reg != '0) ? depth_reg - 1'b1 : depth_reg;
                    state_next = hit_reg ? fct_pkg::ST_CALL : fct_pkg::ST_IDLE;
                end
            end

            fct_pkg::ST_CALL:
            begin
                evt_data.event_res   = fct_pkg::EVT_CALL;
                evt_data.event_pc    = cur_reg.pc;
                evt_data.nest_level  = fct_pkg::LEVEL_W'(dep_after);
                evt_data.name_offset = hit_name_reg;
                evt_data.call_target = cur_reg.target;
                evt_data.last_of_run = 1'b1;
                if (!evt_full)
                begin
                    evt_push   = 1'b1;
                    stk_we     = 1'b1;
                    depth_next = dep_after;
                    state_next = fct_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fct_pkg::ST_IDLE;
            entry_count_reg <= '0;
            idx_reg         <= '0;
            pend_reg        <= 1'b0;
            pend_last_reg   <= 1'b0;
            hit_reg         <= 1'b0;
            depth_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            hit_reg       <= hit_next;
            depth_reg     <= depth_next;
            if (cfg_we)
            begin
                entry_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        hit_name_reg <= hit_name_next;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re)
        begin
            tbl_rd_reg <= tbl_mem[tbl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            frame_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd_reg <= frame_mem[stk_raddr];
        end
    end

    `FCT_ASSERT_IMP(a_depth_bound, 1'b1, depth_reg <= DEP_W'(STACK_DEPTH), "stack depth above limit")
    `FCT_ASSERT_IMP(a_push_state, evt_push, (state_reg == fct_pkg::ST_RET) || (state_reg == fct_pkg::ST_CALL), "event pushed outside an event state")
    `FCT_ASSERT_NXT(a_ret_pop, (state_reg == fct_pkg::ST_RET) && !evt_full, depth_reg == (($past(depth_reg) == '0) ? '0 : $past(depth_reg) - 1'b1), "ret did not pop the stack")
    `FCT_ASSERT_IMP(a_no_pop_busy, req_pop, state_reg == fct_pkg::ST_IDLE, "request taken while busy")

endmodule

`default_nettype wire

// ----- dv/fct_trace_checker.sv -----
// Checker for the function call tracer: watches the request, result and
// register ports, predicts the call and return events and compares them.
// Depends on fct_pkg for the event layout and the encodings.
module fct_trace_checker
    import fct_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned STACK_DEPTH   = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [COUNT_W-1:0] cfg_wdata,
    input  wire logic               push,
    input  wire logic               full,
    input  wire logic               func,
    input  wire logic [SLOT_W-1:0]  slot,
    input  wire logic [XLEN-1:0]    entry_start,
    input  wire logic [XLEN-1:0]    entry_name,
    input  wire logic [XLEN-1:0]    pc,
    input  wire logic [XLEN-1:0]    target,
    input  wire logic [XLEN-1:0]    instr,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire logic               event_res,
    input  wire logic [XLEN-1:0]    event_pc,
    input  wire logic [LEVEL_W-1:0] nest_level,
    input  wire logic [XLEN-1:0]    name_offset,
    input  wire logic [XLEN-1:0]    call_target,
    input  wire logic               last_of_run,
    output int                      mismatches,
    output int                      waiting,
    output int                      calls_seen,
    output int                      rets_seen,
    output int                      deepest,
    output int                      full_calls,
    output int                      empty_rets
);

    localparam int unsigned TBL_AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [XLEN-1:0]    fn_start   [TABLE_ENTRIES];
    logic [XLEN-1:0]    fn_name    [TABLE_ENTRIES];
    logic [XLEN-1:0]    frame_name [STACK_DEPTH];
    logic [COUNT_W-1:0] search_count;
    int                 stack_level;
    fct_evt_t           event_q [$];

    always @(posedge clk or negedge rst_n)
    begin
        fct_evt_t        want;
        fct_evt_t        got;
        int              limit;
        bit              hit;
        bit              is_ret;
        logic [XLEN-1:0] hit_name;

        if (!rst_n)
        begin
            stack_level  = 0;
            search_count = '0;
            event_q.delete();
            mismatches   = 0;
            waiting      = 0;
            calls_seen   = 0;
            rets_seen    = 0;
            deepest      = 0;
            full_calls   = 0;
            empty_rets   = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                got.event_res   = event_res;
                got.event_pc    = event_pc;
                got.nest_level  = nest_level;
                got.name_offset = name_offset;
                got.call_target = call_target;
                got.last_of_run = last_of_run;
                if (event_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected event: res %0d pc %h lvl %0d name %h tgt %h last %0d",
                                 got.event_res, got.event_pc, got.nest_level,
                                 got.name_offset, got.call_target, got.last_of_run);
                end
                else
                begin
                    want = event_q.pop_front();
                    if (got.event_res !== want.event_res || got.event_pc !== want.event_pc ||
                        got.nest_level !== want.nest_level ||
                        got.name_offset !== want.name_offset ||
                        got.call_target !== want.call_target ||
                        got.last_of_run !== want.last_of_run)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("want: res %0d pc %h lvl %0d name %h tgt %h last %0d",
                                     want.event_res, want.event_pc, want.nest_level,
                                     want.name_offset, want.call_target, want.last_of_run);
                            $display(" got: res %0d pc %h lvl %0d name %h tgt %h last %0d",
                                     got.event_res, got.event_pc, got.nest_level,
                                     got.name_offset, got.call_target, got.last_of_run);
                        end
                    end
                end
            end

            if (cfg_we)
                search_count = cfg_wdata;

            if (push && !full)
            begin
                if (func == FUNC_LOAD)
                begin
                    if (slot < TABLE_ENTRIES)
                    begin
                        fn_start[TBL_AW'(slot)] = entry_start;
                        fn_name[TBL_AW'(slot)]  = entry_name;
                    end
                end
                else
                begin
                    // highest matching slot wins, so keep overwriting
                    limit    = (search_count < TABLE_ENTRIES) ? search_count : TABLE_ENTRIES;
                    hit      = 1'b0;
                    hit_name = '0;
                    for (int i = 0; i < limit; i++)
                    begin
                        if (fn_start[TBL_AW'(i)] == target)
                        begin
                            hit      = 1'b1;
                            hit_name = fn_name[TBL_AW'(i)];
                        end
                    end
                    is_ret = (instr == RET_WORD);

                    if (is_ret)
                    begin
                        want.event_res   = EVT_RET;
                        want.event_pc    = pc;
                        want.nest_level  = LEVEL_W'(stack_level);
                        want.name_offset = (stack_level > 0) ?
                                           frame_name[STK_AW'(stack_level - 1)] : '0;
                        want.call_target = '0;
                        want.last_of_run = !hit;
                        event_q.push_back(want);
                        rets_seen++;
                        if (stack_level > 0)
                            stack_level--;
                        else
                            empty_rets++;
                    end
                    if (hit)
                    begin
                        // full stack: depth holds and the top frame is replaced
                        if (stack_level < STACK_DEPTH)
                            stack_level++;
                        else
                            full_calls++;
                        frame_name[STK_AW'(stack_level - 1)] = hit_name;
                        want.event_res   = EVT_CALL;
                        want.event_pc    = pc;
                        want.nest_level  = LEVEL_W'(stack_level);
                        want.name_offset = hit_name;
                        want.call_target = target;
                        want.last_of_run = 1'b1;
                        event_q.push_back(want);
                        calls_seen++;
                        if (stack_level > deepest)
                            deepest = stack_level;
                    end
                end
            end

            waiting = event_q.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
// Top of the function call tracer testbench: clock, reset, request and
// result traffic, register writes and the verdict.
// Depends on fct_pkg, function_call_tracer and fct_trace_checker.
module testbench;
    import fct_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int QUIET_CYCLES = 400;
    localparam int N_PHASES     = 8;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_we      = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata   = '0;
    logic               push        = 1'b0;
    logic               full;
    logic               func        = FUNC_LOAD;
    logic [SLOT_W-1:0]  slot        = '0;
    logic [XLEN-1:0]    entry_start = '0;
    logic [XLEN-1:0]    entry_name  = '0;
    logic [XLEN-1:0]    pc          = '0;
    logic [XLEN-1:0]    target      = '0;
    logic [XLEN-1:0]    instr       = '0;
    logic               empty;
    logic               pop         = 1'b0;
    logic               event_res;
    logic [XLEN-1:0]    event_pc;
    logic [LEVEL_W-1:0] nest_level;
    logic [XLEN-1:0]    name_offset;
    logic [XLEN-1:0]    call_target;
    logic               last_of_run;

    int mismatches;
    int waiting;
    int calls_seen;
    int rets_seen;
    int deepest;
    int full_calls;
    int empty_rets;

    int              sent_count   = 0;
    int              count_writes = 0;
    int              cur_count    = 0;
    bit              tx_quiet     = 1'b0;
    logic            rx_hold      = 1'b0;
    logic [XLEN-1:0] tb_start [64];

    // entry_count per phase; -1 draws a mid-range value
    int ph_cfg  [N_PHASES] = '{64, 127, 1, 0, -1, 64, 96, 33};
    int ph_call [N_PHASES] = '{50, 80, 50, 0, 45, 15, 60, 50};
    int ph_ret  [N_PHASES] = '{40, 10, 50, 60, 45, 75, 35, 45};
    int ph_len  [N_PHASES] = '{200, 150, 100, 80, 200, 120, 150, 150};

    function_call_tracer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .full        (full),
        .func        (func),
        .slot        (slot),
        .entry_start (entry_start),
        .entry_name  (entry_name),
        .pc          (pc),
        .target      (target),
        .instr       (instr),
        .empty       (empty),
        .pop         (pop),
        .event_res   (event_res),
        .event_pc    (event_pc),
        .nest_level  (nest_level),
        .name_offset (name_offset),
        .call_target (call_target),
        .last_of_run (last_of_run)
    );

    fct_trace_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .full        (full),
        .func        (func),
        .slot        (slot),
        .entry_start (entry_start),
        .entry_name  (entry_name),
        .pc          (pc),
        .target      (target),
        .instr       (instr),
        .empty       (empty),
        .pop         (pop),
        .event_res   (event_res),
        .event_pc    (event_pc),
        .nest_level  (nest_level),
        .name_offset (name_offset),
        .call_target (call_target),
        .last_of_run (last_of_run),
        .mismatches  (mismatches),
        .waiting     (waiting),
        .calls_seen  (calls_seen),
        .rets_seen   (rets_seen),
        .deepest     (deepest),
        .full_calls  (full_calls),
        .empty_rets  (empty_rets)
    );

    always #10 clk = ~clk;

    // one request on the input side, after a random gap unless tx_quiet is set
    task automatic offer(input logic f, input logic [SLOT_W-1:0] s,
                         input logic [XLEN-1:0] es, input logic [XLEN-1:0] en,
                         input logic [XLEN-1:0] pv, input logic [XLEN-1:0] tv,
                         input logic [XLEN-1:0] iv);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func        <= f;
        slot        <= s;
        entry_start <= es;
        entry_name  <= en;
        pc          <= pv;
        target      <= tv;
        instr       <= iv;
        push        <= 1'b1;
        do
            @(posedge clk);
        while (full);
        sent_count++;
    endtask

    task automatic load_slot(input logic [SLOT_W-1:0] s, input logic [XLEN-1:0] st,
                             input logic [XLEN-1:0] nm);
        tb_start[s] = st;
        offer(FUNC_LOAD, s, st, nm, $urandom, $urandom, $urandom);
    endtask

    task automatic trace(input logic [XLEN-1:0] pv, input logic [XLEN-1:0] tv,
                         input logic [XLEN-1:0] iv);
        offer(FUNC_TRACE, SLOT_W'($urandom), $urandom, $urandom, pv, tv, iv);
    endtask

    // drain the block, allow for requests that give no event, then write
    task automatic write_count(input int v);
        push <= 1'b0;
        do
            @(negedge clk);
        while (waiting != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
        cfg_wdata <= COUNT_W'(v);
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_count = v;
        count_writes++;
    endtask

    initial
    begin
        int              roll;
        int              lim;
        int              v;
        logic [XLEN-1:0] tv;
        logic [XLEN-1:0] iv;
        logic [XLEN-1:0] st;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing searched after reset
        trace(32'h0000_0100, 32'h0000_0000, RET_WORD);
        trace(32'h0000_0104, 32'h0000_1000, 32'h0000_0013);
        load_slot(6'd0, 32'h0000_0000, 32'hFFFF_FFFF);
        load_slot(6'd1, 32'hFFFF_FFFF, 32'h0000_0000);
        load_slot(6'd2, 32'h8000_0000, 32'h0000_0011);
        load_slot(6'd3, 32'h0000_1000, 32'h0000_0022);
        load_slot(6'd4, 32'h0000_2000, 32'h0000_0044);
        load_slot(6'd5, 32'h8000_0000, 32'h0000_0055); // duplicate start, slot 5 wins
        load_slot(6'd6, 32'h0000_3000, 32'h0000_0066);
        load_slot(6'd7, 32'h0000_4000, 32'h0000_0077);
        write_count(8);
        trace(32'h0000_0000, 32'h0000_1000, 32'h0000_0013);
        trace(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        trace(32'h0000_0010, 32'h0000_0000, RET_WORD);         // ret then call
        trace(32'h0000_0014, 32'h0000_5000, RET_WORD);
        trace(32'h0000_0018, 32'h0000_5000, RET_WORD ^ 32'h1); // near miss
        trace(32'h0000_001C, 32'hFFFF_FFFF, 32'h0000_0000);
        trace(32'h0000_0020, 32'h0000_4000, RET_WORD);
        trace(32'h0000_0024, 32'h0000_6000, RET_WORD);
        trace(32'h0000_0028, 32'h0000_6000, RET_WORD);
        trace(32'h0000_002C, 32'h0000_6000, RET_WORD);         // stack already empty

        // fill the whole table; some starts repeat so several slots match
        for (int s = 0; s < 64; s++)
        begin
            st = (s > 0 && $urandom_range(0, 3) == 0) ?
                 tb_start[SLOT_W'($urandom_range(0, s - 1))] : $urandom;
            load_slot(SLOT_W'(s), st, $urandom);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            v = (ph_cfg[p] < 0) ? $urandom_range(2, 63) : ph_cfg[p];
            write_count(v);
            tx_quiet = (p % 3 == 1);
            for (int k = 0; k < ph_len[p]; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 7)
                begin
                    st = ($urandom_range(0, 3) == 0) ?
                         tb_start[SLOT_W'($urandom_range(0, 63))] : $urandom;
                    load_slot(SLOT_W'($urandom), st, $urandom);
                end
                else
                begin
                    lim = (cur_count < 64) ? cur_count : 64;
                    if (lim > 0 && $urandom_range(0, 99) < ph_call[p])
                        tv = tb_start[SLOT_W'($urandom_range(0, lim - 1))];
                    else
                        tv = $urandom;
                    roll = $urandom_range(0, 99);
                    if (roll < ph_ret[p])
                        iv = RET_WORD;
                    else if (roll < ph_ret[p] + 5)
                        iv = RET_WORD ^ (32'h1 << $urandom_range(0, 31));
                    else
                        iv = $urandom;
                    trace($urandom, tv, iv);
                end
            end
        end

        push <= 1'b0;
        do
            @(negedge clk);
        while (waiting != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("%0d requests over %0d entry_count settings; %0d call and %0d return events",
                 sent_count, count_writes, calls_seen, rets_seen);
        $display("deepest level %0d, %0d calls on a full stack, %0d returns on an empty stack",
                 deepest, full_calls, empty_rets);
        if (mismatches == 0 && waiting == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // result side: random gaps, with quiet stretches now and then
    initial
    begin
        int gap;
        bit rx_quiet;

        rx_quiet = 1'b0;
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_quiet = !rx_quiet;
            gap = rx_quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0 || rx_hold)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
                while (rx_hold)
                    @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
        end
    end

    // long hold-off on the result side while requests keep coming
    initial
    begin
        while (sent_count < 400)
            @(negedge clk);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #(20 * LIMIT_CYCLES);
        $display("testbench: FAIL");
        $finish;
    end

endmodule
